[rtl/e2r_pkg.sv]
// Package: constants, types and helpers for the Euler-to-rotation block.
package e2r_pkg;
   localparam int STEPS = 24;
   localparam int ZW = 34;   // angle in Q.30 over the full range
   localparam int XW = 33;   // CORDIC x/y, Q.30 with headroom
   localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [XW-1:0] GAIN = 33'sh026DD3B6A;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } cord_type;

   typedef struct packed {
      cord_type r;
      cord_type p;
      cord_type w;
   } trio_type;

   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0: atan_q30 = 34'sh03243F6A8;
         5'd1: atan_q30 = 34'sh01DAC6705;
         5'd2: atan_q30 = 34'sh00FADBAFC;
         5'd3: atan_q30 = 34'sh007F56EA6;
         5'd4: atan_q30 = 34'sh003FEAB76;
         5'd5: atan_q30 = 34'sh001FFD55B;
         5'd6: atan_q30 = 34'sh000FFFAAA;
         5'd7: atan_q30 = 34'sh0007FFF55;
         5'd8: atan_q30 = 34'sh0003FFFEA;
         5'd9: atan_q30 = 34'sh0001FFFFD;
         5'd10: atan_q30 = 34'sh0000FFFFF;
         5'd11: atan_q30 = 34'sh00007FFFF;
         5'd12: atan_q30 = 34'sh00003FFFF;
         5'd13: atan_q30 = 34'sh00001FFFF;
         5'd14: atan_q30 = 34'sh00000FFFF;
         5'd15: atan_q30 = 34'sh000007FFF;
         5'd16: atan_q30 = 34'sh000003FFF;
         5'd17: atan_q30 = 34'sh000001FFF;
         5'd18: atan_q30 = 34'sh000000FFF;
         5'd19: atan_q30 = 34'sh0000007FF;
         5'd20: atan_q30 = 34'sh0000003FF;
         5'd21: atan_q30 = 34'sh0000001FF;
         5'd22: atan_q30 = 34'sh0000000FF;
         5'd23: atan_q30 = 34'sh00000007F;
         default: atan_q30 = '0;
      endcase
   endfunction

   function automatic logic signed [15:0] clamp16(input logic signed [47:0] v);
      if (v > 48'sd16384) clamp16 = ONE_Q14;
      else if (v < -48'sd16384) clamp16 = -ONE_Q14;
      else clamp16 = v[15:0];
   endfunction
endpackage

[rtl/e2r_cell.sv]
// One CORDIC micro-rotation for all three angles, registered.
module e2r_cell (
   input  logic                clock,
   input  logic                en,
   input  logic [4:0]          shift,
   input  e2r_pkg::trio_type   d_in,
   input  logic [2:0]          neg_in,
   output e2r_pkg::trio_type   d_out,
   output logic [2:0]          neg_out
);
   import e2r_pkg::*;

   function automatic cord_type rot(input cord_type c, input logic [4:0] s);
      cord_type o;
      logic signed [ZW-1:0] a;
      a = atan_q30(s);
      if (!c.z[ZW-1]) begin
         o.x = c.x - (c.y >>> s);
         o.y = c.y + (c.x >>> s);
         o.z = c.z - a;
      end else begin
         o.x = c.x + (c.y >>> s);
         o.y = c.y - (c.x >>> s);
         o.z = c.z + a;
      end
      return o;
   endfunction

   trio_type d_ff;
   logic [2:0] neg_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff.r <= rot(d_in.r, shift);
         d_ff.p <= rot(d_in.p, shift);
         d_ff.w <= rot(d_in.w, shift);
         neg_ff <= neg_in;
      end
   end
   assign d_out = d_ff;
   assign neg_out = neg_ff;
endmodule

[rtl/e2r_matrix.sv]
// Rounding of sin/cos and two-stage matrix product pipeline.
module e2r_matrix (
   input  logic               clock,
   input  logic [2:0]         en,
   input  e2r_pkg::trio_type  d_in,
   input  logic [2:0]         neg_in,
   output logic signed [15:0] m [9]
);
   import e2r_pkg::*;

   function automatic logic signed [15:0] rnd(input logic signed [XW-1:0] v,
                                               input logic n);
      logic signed [XW+1:0] t;
      t = (n ? -{{2{v[XW-1]}}, v} : {{2{v[XW-1]}}, v}) + 35'sd32768;
      return clamp16(48'(t >>> 16));
   endfunction

   // stage A: sin/cos
   logic signed [15:0] sx_ff, cx_ff, sy_ff, cy_ff, sz_ff, cz_ff;
   always_ff @(posedge clock) begin
      if (en[0]) begin
         cx_ff <= rnd(d_in.r.x, neg_in[0]); sx_ff <= rnd(d_in.r.y, neg_in[0]);
         cy_ff <= rnd(d_in.p.x, neg_in[1]); sy_ff <= rnd(d_in.p.y, neg_in[1]);
         cz_ff <= rnd(d_in.w.x, neg_in[2]); sz_ff <= rnd(d_in.w.y, neg_in[2]);
      end
   end

   // stage B: pair products, Q.28; carry singles along
   logic signed [31:0] czcy_ff, szsx_ff, czsy_ff, szcx_ff, cycx_ff, cysx_ff, szcy_ff;
   logic signed [31:0] szsy_ff, czsx_ff, czcx_ff;
   logic signed [15:0] sxb_ff, cxb_ff, syb_ff;
   always_ff @(posedge clock) begin
      if (en[1]) begin
         czcy_ff <= cz_ff * cy_ff; szsx_ff <= sz_ff * sx_ff;
         czsy_ff <= cz_ff * sy_ff; szcx_ff <= sz_ff * cx_ff;
         cycx_ff <= cy_ff * cx_ff; cysx_ff <= cy_ff * sx_ff;
         szcy_ff <= sz_ff * cy_ff; szsy_ff <= sz_ff * sy_ff;
         czsx_ff <= cz_ff * sx_ff; czcx_ff <= cz_ff * cx_ff;
         sxb_ff <= sx_ff; cxb_ff <= cx_ff; syb_ff <= sy_ff;
      end
   end

   // stage C: triple products, sums in Q.42, round once
   function automatic logic signed [15:0] fin(input logic signed [47:0] s);
      logic signed [47:0] t;
      t = (s + 48'sd134217728) >>> 28;
      return clamp16(t);
   endfunction
   function automatic logic signed [47:0] two(input logic signed [31:0] p);
      return {{2{p[31]}}, p, 14'b0};
   endfunction

   logic signed [47:0] t_a, t_b, t_c;
   always_comb begin
      t_a = 48'(czsy_ff) * 48'(cxb_ff);
      t_b = 48'(czsy_ff) * 48'(sxb_ff);
      t_c = 48'(szsy_ff) * 48'(cxb_ff);
   end
   logic signed [15:0] m_ff [9];
   logic signed [47:0] t_d;
   assign t_d = 48'(szsy_ff) * 48'(sxb_ff);
   always_ff @(posedge clock) begin
      if (en[2]) begin
         m_ff[0] <= fin(two(czcy_ff));
         m_ff[1] <= fin(two(szsx_ff) - t_a);
         m_ff[2] <= fin(t_b + two(szcx_ff));
         m_ff[3] <= fin({{4{syb_ff[15]}}, syb_ff, 28'b0});
         m_ff[4] <= fin(two(cycx_ff));
         m_ff[5] <= fin(-two(cysx_ff));
         m_ff[6] <= fin(-two(szcy_ff));
         m_ff[7] <= fin(t_c + two(czsx_ff));
         m_ff[8] <= fin(two(czcx_ff) - t_d);
      end
   end
   assign m = m_ff;
endmodule

[rtl/euler_to_rotation_matrix_top.sv]
// Top level: Euler angles to 3x3 rotation matrix, CORDIC cell chain.
//  channel | dir | payload
//  req_*   | in  | roll, pitch, yaw (Q3.13)
//  rsp_*   | out | r00..r22 (Q1.14)
// One request per cycle while the pipe advances; stages are range fold,
// 24 CORDIC cells, sin/cos round and two product stages.
// The whole pipe advances when the last stage is empty or taken, so
// backpressure stalls every stage together. Reset clears valid bits only.
module euler_to_rotation_matrix_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,  // roll[15:0], pitch[31:16], yaw[47:32]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata   // r00,r01,r02,r10,r11,r12,r20,r21,r22
);
   import e2r_pkg::*;
   localparam int NST = STEPS + 4;

   logic [NST-1:0] vld_ff;
   logic adv;
   assign adv = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NST-2:0], req_tvalid};
   end

   // range fold by pi
   function automatic cord_type fold(input logic signed [15:0] a);
      cord_type c;
      logic signed [ZW-1:0] z;
      z = {a[15], a, 17'b0};
      if (z > HALF_PI_Q30) z = z - PI_Q30;
      else if (z < -HALF_PI_Q30) z = z + PI_Q30;
      c.x = GAIN; c.y = '0; c.z = z;
      return c;
   endfunction

   // set when the fold flips the sign of sin and cos
   function automatic logic folds(input logic signed [15:0] a);
      logic signed [ZW-1:0] z;
      z = {a[15], a, 17'b0};
      return (z > HALF_PI_Q30) || (z < -HALF_PI_Q30);
   endfunction

   trio_type f_in, f_ff;
   logic [2:0] fn_in, fn_ff;
   always_comb begin
      f_in.r = fold(req_tdata[15:0]);
      f_in.p = fold(req_tdata[31:16]);
      f_in.w = fold(req_tdata[47:32]);
      fn_in = {folds(req_tdata[47:32]), folds(req_tdata[31:16]), folds(req_tdata[15:0])};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff <= f_in;
         fn_ff <= fn_in;
      end
   end

   trio_type chain [STEPS+1];
   logic [2:0] negc [STEPS+1];
   assign chain[0] = f_ff;
   assign negc[0] = fn_ff;
   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      e2r_cell u_cell (
         .clock(clock), .en(adv), .shift(5'(i)),
         .d_in(chain[i]), .neg_in(negc[i]),
         .d_out(chain[i+1]), .neg_out(negc[i+1])
      );
   end

   logic signed [15:0] m [9];
   e2r_matrix u_mat (
      .clock(clock), .en({3{adv}}), .d_in(chain[STEPS]), .neg_in(negc[STEPS]), .m(m)
   );

   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tdata = {m[8], m[7], m[6], m[5], m[4], m[3], m[2], m[1], m[0]};
endmodule
